// ===== hw/rtl/bpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear patch tessellator package
// Payload types, register indexes, corner codes and the vertex order table.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int MAX_GRID_DEF   = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VERTS_PER_CELL = 6;
  localparam int AXES           = 3;
  localparam int CORNERS        = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;
  localparam logic [CFG_W-1:0]     GRID_RESET    = 9'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_CELL = 1'b1;

  localparam logic [1:0] CORNER_00 = 2'd0;
  localparam logic [1:0] CORNER_10 = 2'd1;
  localparam logic [1:0] CORNER_01 = 2'd2;
  localparam logic [1:0] CORNER_11 = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [1:0]         corner_sel;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
  } req_t;

  typedef struct packed {
    logic [15:0]        vertex_index;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               last_vertex;
  } vtx_t;

  // {column step, row step} of vertex k of a cell
  function automatic logic [1:0] vert_offset(input logic odd, input logic [2:0] k);
    logic [1:0] ofs;
    ofs = 2'b00;
    if (odd) begin
      unique case (k)
        3'd0: ofs = 2'b00;
        3'd1: ofs = 2'b10;
        3'd2: ofs = 2'b11;
        3'd3: ofs = 2'b00;
        3'd4: ofs = 2'b11;
        3'd5: ofs = 2'b01;
        default: ofs = 2'b00;
      endcase
    end else begin
      unique case (k)
        3'd0: ofs = 2'b01;
        3'd1: ofs = 2'b00;
        3'd2: ofs = 2'b10;
        3'd3: ofs = 2'b01;
        3'd4: ofs = 2'b10;
        3'd5: ofs = 2'b11;
        default: ofs = 2'b00;
      endcase
    end
    return ofs;
  endfunction

endpackage

// ===== hw/rtl/bilinear_patch_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear patch tessellator
// Stores four patch corners and emits the six triangle vertices of a grid cell.
// ----------------------------------------------------------------------------
// A corner load is one transaction and produces nothing; a cell request inside
// the grid produces six vertex transactions, one per cycle while vtx_stall does
// not hold the pipeline, and the next request is taken only as the sixth vertex
// leaves the input register, a limit set by the single vertex output. Loads and
// requests that fall outside the grid are taken one per cycle under the same
// condition. The first vertex is offered on vtx after an input register, a
// weight divider retiring four quotient bits per stage for row and column
// weights, then six stages of edge and cross interpolation ending in the output
// register. Corner loads travel down the same pipeline and update the corner
// registers in order with the requests around them. The whole pipeline holds while a vertex waits on vtx_stall.
module bilinear_patch_tessellator #(
  parameter int MAX_GRID  = bpt_pkg::MAX_GRID_DEF,
  parameter int FRAC_BITS = bpt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpt_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  bpt_pkg::req_t                req,
  output logic                         vtx_valid,
  input  logic                         vtx_stall,
  output bpt_pkg::vtx_t                vtx
);

  localparam int WW             = FRAC_BITS + 1;
  localparam int PW             = 33 + WW + 1;
  localparam int BITS_PER_STAGE = 4;
  localparam int DS             = (FRAC_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  typedef struct packed {
    logic        load;
    logic        last;
    logic [7:0]  ci;
    logic [7:0]  ri;
    logic [1:0]  sel;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } tok_t;

  typedef struct packed {
    tok_t          tok;
    logic [7:0]    rem_c;
    logic [7:0]    rem_r;
    logic [WW-1:0] w_c;
    logic [WW-1:0] w_r;
  } dst_t;

  logic [bpt_pkg::CFG_W-1:0] grid_cols, grid_rows;
  logic [8:0] cols_eff, rows_eff, cols_m1, rows_m1;
  logic [7:0] d_c, d_r;
  logic       adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= bpt_pkg::GRID_RESET;
      grid_rows <= bpt_pkg::GRID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpt_pkg::REG_GRID_COLS: grid_cols <= cfg_data;
        bpt_pkg::REG_GRID_ROWS: grid_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cols_eff = (grid_cols > 9'(MAX_GRID)) ? 9'(MAX_GRID) : grid_cols;
  assign rows_eff = (grid_rows > 9'(MAX_GRID)) ? 9'(MAX_GRID) : grid_rows;
  assign cols_m1  = cols_eff - 9'd1;
  assign rows_m1  = rows_eff - 9'd1;
  assign d_c      = cols_m1[7:0];
  assign d_r      = rows_m1[7:0];

  // input register and vertex sequencer
  logic          s0_valid;
  bpt_pkg::req_t s0_item;
  logic [2:0]    s0_cnt;
  logic          s0_load, s0_in_grid, s0_done, s0_odd;
  logic [1:0]    s0_ofs;
  tok_t          s0_tok;

  assign s0_load    = s0_item.mode == bpt_pkg::MODE_LOAD;
  assign s0_in_grid = (cols_eff >= 9'd2) && (rows_eff >= 9'd2) &&
                      ({1'b0, s0_item.cell_col} < cols_m1) &&
                      ({1'b0, s0_item.cell_row} < rows_m1);
  assign s0_done    = s0_load || !s0_in_grid ||
                      (s0_cnt == 3'(bpt_pkg::VERTS_PER_CELL - 1));
  assign s0_odd     = s0_item.cell_col[0] ^ s0_item.cell_row[0];
  assign s0_ofs     = bpt_pkg::vert_offset(s0_odd, s0_cnt);
  assign req_stall  = s0_valid && !(adv && s0_done);

  always_comb begin
    s0_tok.load = s0_load;
    s0_tok.last = s0_cnt == 3'(bpt_pkg::VERTS_PER_CELL - 1);
    s0_tok.ci   = s0_item.cell_col + 8'(s0_ofs[1]);
    s0_tok.ri   = s0_item.cell_row + 8'(s0_ofs[0]);
    s0_tok.sel  = s0_item.corner_sel;
    s0_tok.x    = s0_item.pos_x;
    s0_tok.y    = s0_item.pos_y;
    s0_tok.z    = s0_item.pos_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s0_cnt   <= 3'd0;
    end else if (req_valid && !req_stall) begin
      s0_valid <= 1'b1;
      s0_cnt   <= 3'd0;
    end else if (adv && s0_valid) begin
      if (s0_done) begin
        s0_valid <= 1'b0;
      end else begin
        s0_cnt <= s0_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s0_item <= req;
    end
  end

  // weight divider: w = floor(i * 2^FRAC_BITS / (n - 1)), with i <= n - 1
  logic [DS:0] dvld;
  dst_t        dst [DS+1];
  logic        q0_c, q0_r;

  assign q0_c = s0_tok.ci == d_c;
  assign q0_r = s0_tok.ri == d_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (adv) begin
      dvld[0] <= s0_valid && (s0_load || s0_in_grid);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst[0].tok   <= s0_tok;
      dst[0].rem_c <= q0_c ? 8'd0 : s0_tok.ci;
      dst[0].rem_r <= q0_r ? 8'd0 : s0_tok.ri;
      dst[0].w_c   <= WW'(q0_c);
      dst[0].w_r   <= WW'(q0_r);
    end
  end

  for (genvar g = 1; g <= DS; g++) begin : g_div
    dst_t       nxt;
    logic [8:0] tc, tr;

    always_comb begin
      nxt = dst[g-1];
      tc  = 9'd0;
      tr  = 9'd0;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        if ((g - 1) * BITS_PER_STAGE + j < FRAC_BITS) begin
          tc = {nxt.rem_c, 1'b0};
          if (tc >= {1'b0, d_c}) begin
            nxt.rem_c = 8'(tc - {1'b0, d_c});
            nxt.w_c   = {nxt.w_c[WW-2:0], 1'b1};
          end else begin
            nxt.rem_c = tc[7:0];
            nxt.w_c   = {nxt.w_c[WW-2:0], 1'b0};
          end
          tr = {nxt.rem_r, 1'b0};
          if (tr >= {1'b0, d_r}) begin
            nxt.rem_r = 8'(tr - {1'b0, d_r});
            nxt.w_r   = {nxt.w_r[WW-2:0], 1'b1};
          end else begin
            nxt.rem_r = tr[7:0];
            nxt.w_r   = {nxt.w_r[WW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[g] <= 1'b0;
      end else if (adv) begin
        dvld[g] <= dvld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dst[g] <= nxt;
      end
    end
  end

  // corner registers, updated in pipeline order
  logic [31:0] corner_store [bpt_pkg::CORNERS][bpt_pkg::AXES];
  tok_t        dtok;

  assign dtok = dst[DS].tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bpt_pkg::CORNERS; k++) begin
        for (int ax = 0; ax < bpt_pkg::AXES; ax++) begin
          corner_store[k][ax] <= 32'd0;
        end
      end
    end else if (adv && dvld[DS] && dtok.load) begin
      corner_store[dtok.sel][0] <= dtok.x;
      corner_store[dtok.sel][1] <= dtok.y;
      corner_store[dtok.sel][2] <= dtok.z;
    end
  end

  // edge differences and grid index
  logic                l1_valid, l1_last;
  logic [15:0]         l1_idx;
  logic [WW-1:0]       l1_wr, l1_wc;
  logic signed [31:0]  l1_a  [bpt_pkg::AXES];
  logic signed [31:0]  l1_b  [bpt_pkg::AXES];
  logic signed [32:0]  l1_da [bpt_pkg::AXES];
  logic signed [32:0]  l1_db [bpt_pkg::AXES];
  logic [16:0]         idx_full;

  assign idx_full = 17'(dtok.ri) * 17'(cols_eff) + 17'(dtok.ci);

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
    end else if (adv) begin
      l1_valid <= dvld[DS] && !dtok.load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_last <= dtok.last;
      l1_idx  <= idx_full[15:0];
      l1_wr   <= dst[DS].w_r;
      l1_wc   <= dst[DS].w_c;
      for (int ax = 0; ax < bpt_pkg::AXES; ax++) begin
        l1_a[ax]  <= $signed(corner_store[bpt_pkg::CORNER_00][ax]);
        l1_b[ax]  <= $signed(corner_store[bpt_pkg::CORNER_10][ax]);
        l1_da[ax] <= $signed({corner_store[bpt_pkg::CORNER_01][ax][31],
                              corner_store[bpt_pkg::CORNER_01][ax]}) -
                     $signed({corner_store[bpt_pkg::CORNER_00][ax][31],
                              corner_store[bpt_pkg::CORNER_00][ax]});
        l1_db[ax] <= $signed({corner_store[bpt_pkg::CORNER_11][ax][31],
                              corner_store[bpt_pkg::CORNER_11][ax]}) -
                     $signed({corner_store[bpt_pkg::CORNER_10][ax][31],
                              corner_store[bpt_pkg::CORNER_10][ax]});
      end
    end
  end

  // edge products by the row weight
  logic                l2_valid, l2_last;
  logic [15:0]         l2_idx;
  logic [WW-1:0]       l2_wc;
  logic signed [31:0]  l2_a  [bpt_pkg::AXES];
  logic signed [31:0]  l2_b  [bpt_pkg::AXES];
  logic signed [PW-1:0] l2_pa [bpt_pkg::AXES];
  logic signed [PW-1:0] l2_pb [bpt_pkg::AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_valid <= 1'b0;
    end else if (adv) begin
      l2_valid <= l1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_last <= l1_last;
      l2_idx  <= l1_idx;
      l2_wc   <= l1_wc;
      for (int ax = 0; ax < bpt_pkg::AXES; ax++) begin
        l2_a[ax]  <= l1_a[ax];
        l2_b[ax]  <= l1_b[ax];
        l2_pa[ax] <= PW'(l1_da[ax]) * PW'($signed({1'b0, l1_wr}));
        l2_pb[ax] <= PW'(l1_db[ax]) * PW'($signed({1'b0, l1_wr}));
      end
    end
  end

  // left and right edge points
  logic                l3_valid, l3_last;
  logic [15:0]         l3_idx;
  logic [WW-1:0]       l3_wc;
  logic signed [31:0]  l3_left  [bpt_pkg::AXES];
  logic signed [31:0]  l3_right [bpt_pkg::AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      l3_valid <= 1'b0;
    end else if (adv) begin
      l3_valid <= l2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l3_last <= l2_last;
      l3_idx  <= l2_idx;
      l3_wc   <= l2_wc;
      for (int ax = 0; ax < bpt_pkg::AXES; ax++) begin
        l3_left[ax]  <= l2_a[ax] + 32'(l2_pa[ax] >>> FRAC_BITS);
        l3_right[ax] <= l2_b[ax] + 32'(l2_pb[ax] >>> FRAC_BITS);
      end
    end
  end

  // cross difference
  logic                l4_valid, l4_last;
  logic [15:0]         l4_idx;
  logic [WW-1:0]       l4_wc;
  logic signed [31:0]  l4_left [bpt_pkg::AXES];
  logic signed [32:0]  l4_d    [bpt_pkg::AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      l4_valid <= 1'b0;
    end else if (adv) begin
      l4_valid <= l3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l4_last <= l3_last;
      l4_idx  <= l3_idx;
      l4_wc   <= l3_wc;
      for (int ax = 0; ax < bpt_pkg::AXES; ax++) begin
        l4_left[ax] <= l3_left[ax];
        l4_d[ax]    <= $signed({l3_right[ax][31], l3_right[ax]}) -
                       $signed({l3_left[ax][31], l3_left[ax]});
      end
    end
  end

  // cross product by the column weight
  logic                 l5_valid, l5_last;
  logic [15:0]          l5_idx;
  logic signed [31:0]   l5_left [bpt_pkg::AXES];
  logic signed [PW-1:0] l5_p    [bpt_pkg::AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      l5_valid <= 1'b0;
    end else if (adv) begin
      l5_valid <= l4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l5_last <= l4_last;
      l5_idx  <= l4_idx;
      for (int ax = 0; ax < bpt_pkg::AXES; ax++) begin
        l5_left[ax] <= l4_left[ax];
        l5_p[ax]    <= PW'(l4_d[ax]) * PW'($signed({1'b0, l4_wc}));
      end
    end
  end

  // output register
  logic          out_valid;
  bpt_pkg::vtx_t out_data;

  assign adv       = !out_valid || !vtx_stall;
  assign vtx_valid = out_valid;
  assign vtx       = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= l5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.vertex_index <= l5_idx;
      out_data.vert_x       <= l5_left[0] + 32'(l5_p[0] >>> FRAC_BITS);
      out_data.vert_y       <= l5_left[1] + 32'(l5_p[1] >>> FRAC_BITS);
      out_data.vert_z       <= l5_left[2] + 32'(l5_p[2] >>> FRAC_BITS);
      out_data.last_vertex  <= l5_last;
    end
  end

endmodule

// ===== test/bilinear_patch_tessellator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear patch tessellator testbench
// Loads patch corners and requests grid cells over several grid sizes, with
// random gaps on the request side and random stalls on the vertex side. Every
// vertex that leaves the block is checked, field by field, against a
// fixed-point model of the patch that is kept in step with the requests taken.
// ----------------------------------------------------------------------------
module bilinear_patch_tessellator_tb;

  localparam int FRAC = bpt_pkg::FRAC_BITS_DEF;
  localparam int MAXG = bpt_pkg::MAX_GRID_DEF;

  // vertex k of a cell takes bit k as its column and row step
  localparam bit [5:0] ODD_COL_STEP  = 6'b010110;
  localparam bit [5:0] ODD_ROW_STEP  = 6'b110100;
  localparam bit [5:0] EVEN_COL_STEP = 6'b110100;
  localparam bit [5:0] EVEN_ROW_STEP = 6'b101001;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index = bpt_pkg::REG_GRID_COLS;
  logic [bpt_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  bpt_pkg::req_t                 req = '0;
  logic                          vtx_valid;
  logic                          vtx_stall = 1'b0;
  bpt_pkg::vtx_t                 vtx;

  bpt_pkg::req_t             pending_reqs[$];
  bpt_pkg::vtx_t             expected_vertices[$];
  logic signed [31:0]        corner_pos[bpt_pkg::CORNERS][bpt_pkg::AXES];
  logic [bpt_pkg::CFG_W-1:0] cols_reg = bpt_pkg::GRID_RESET;
  logic [bpt_pkg::CFG_W-1:0] rows_reg = bpt_pkg::GRID_RESET;
  int                        errors = 0;
  int                        gap_left = 0;
  int                        stall_left = 0;
  int                        calm_in = 0;
  int                        calm_out = 0;

  bilinear_patch_tessellator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int s = 0; s < bpt_pkg::CORNERS; s++) begin
      for (int a = 0; a < bpt_pkg::AXES; a++) begin
        corner_pos[s][a] = '0;
      end
    end
  end

  function automatic int eff_size(logic [bpt_pkg::CFG_W-1:0] n);
    return (int'(n) > MAXG) ? MAXG : int'(n);
  endfunction

  function automatic longint grid_weight(int i, int n);
    return (longint'(i) << FRAC) / longint'(n - 1);
  endfunction

  // floor division of the scaled step, so a negative step rounds down
  function automatic longint blend(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> FRAC);
  endfunction

  function automatic void predict_request(bpt_pkg::req_t t);
    int            cols;
    int            rows;
    int            c;
    int            r;
    int            vc;
    int            vr;
    bit            odd;
    longint        wc;
    longint        wr;
    longint        left;
    longint        right;
    longint        v;
    bpt_pkg::vtx_t e;
    if (t.mode == bpt_pkg::MODE_LOAD) begin
      corner_pos[t.corner_sel][0] = t.pos_x;
      corner_pos[t.corner_sel][1] = t.pos_y;
      corner_pos[t.corner_sel][2] = t.pos_z;
      return;
    end
    cols = eff_size(cols_reg);
    rows = eff_size(rows_reg);
    if (cols < 2 || rows < 2) return;
    c = int'(t.cell_col);
    r = int'(t.cell_row);
    if (c >= cols - 1 || r >= rows - 1) return;
    odd = ((c + r) % 2) != 0;
    for (int k = 0; k < bpt_pkg::VERTS_PER_CELL; k++) begin
      vc = c + int'(odd ? ODD_COL_STEP[k] : EVEN_COL_STEP[k]);
      vr = r + int'(odd ? ODD_ROW_STEP[k] : EVEN_ROW_STEP[k]);
      wc = grid_weight(vc, cols);
      wr = grid_weight(vr, rows);
      e.vertex_index = 16'(vr * cols + vc);
      for (int a = 0; a < bpt_pkg::AXES; a++) begin
        left  = blend(longint'(corner_pos[bpt_pkg::CORNER_00][a]),
                      longint'(corner_pos[bpt_pkg::CORNER_01][a]), wr);
        right = blend(longint'(corner_pos[bpt_pkg::CORNER_10][a]),
                      longint'(corner_pos[bpt_pkg::CORNER_11][a]), wr);
        v     = blend(left, right, wc);
        case (a)
          0: e.vert_x = v[31:0];
          1: e.vert_y = v[31:0];
          default: e.vert_z = v[31:0];
        endcase
      end
      e.last_vertex = (k == bpt_pkg::VERTS_PER_CELL - 1);
      expected_vertices.push_back(e);
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm_in > 0) begin
      calm_in--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 4) begin
      calm_in = $urandom_range(8, 25);
      return 0;
    end
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int p;
    if (calm_out > 0) begin
      calm_out--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 3) begin
      calm_out = $urandom_range(20, 60);
      return 0;
    end
    if (p < 70) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 100) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // request driver: advance to the next pending transaction once taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) predict_request(req);
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // vertex monitor
  always @(posedge clk) begin
    int            n;
    bpt_pkg::vtx_t e;
    if (!rst && vtx_valid && !vtx_stall) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch($sformatf("unexpected vertex, index %0d", vtx.vertex_index));
      end else begin
        e = expected_vertices.pop_front();
        check_field("vertex_index", 32'(vtx.vertex_index), 32'(e.vertex_index));
        check_field("vert_x", vtx.vert_x, e.vert_x);
        check_field("vert_y", vtx.vert_y, e.vert_y);
        check_field("vert_z", vtx.vert_z, e.vert_z);
        check_field("last_vertex", 32'(vtx.last_vertex), 32'(e.last_vertex));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      vtx_stall <= 1'b1;
    end else begin
      n = pick_stall();
      vtx_stall <= (n > 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bpt_pkg::req_t load_item(logic [1:0] sel, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z);
    bpt_pkg::req_t t;
    t.mode       = bpt_pkg::MODE_LOAD;
    t.corner_sel = sel;
    t.pos_x      = x;
    t.pos_y      = y;
    t.pos_z      = z;
    t.cell_col   = 8'($urandom);
    t.cell_row   = 8'($urandom);
    return t;
  endfunction

  function automatic bpt_pkg::req_t cell_item(int c, int r);
    bpt_pkg::req_t t;
    t.mode       = bpt_pkg::MODE_CELL;
    t.corner_sel = 2'($urandom);
    t.pos_x      = $urandom;
    t.pos_y      = $urandom;
    t.pos_z      = $urandom;
    t.cell_col   = 8'(c);
    t.cell_row   = 8'(r);
    return t;
  endfunction

  // hold until the request side is empty and every vertex has been seen
  task automatic drain_all();
    while (pending_reqs.size() > 0 || req_valid || expected_vertices.size() > 0) begin
      @(negedge clk);
    end
    repeat (24) @(negedge clk);
  endtask

  task automatic set_grid(logic [bpt_pkg::CFG_W-1:0] cols, logic [bpt_pkg::CFG_W-1:0] rows);
    drain_all();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= bpt_pkg::REG_GRID_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= bpt_pkg::REG_GRID_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_write <= 1'b0;
    cols_reg = cols;
    rows_reg = rows;
  endtask

  task automatic random_phase(int count);
    int cols;
    int rows;
    int p;
    cols = eff_size(cols_reg);
    rows = eff_size(rows_reg);
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 9);
      if (p < 2) begin
        pending_reqs.push_back(load_item(2'($urandom), rand_coord(), rand_coord(),
                                         rand_coord()));
      end else if (cols < 2 || rows < 2) begin
        pending_reqs.push_back(cell_item($urandom_range(0, 255), $urandom_range(0, 255)));
      end else if (p == 2) begin
        if ($urandom_range(0, 1))
          pending_reqs.push_back(cell_item($urandom_range(cols - 1, 255),
                                           $urandom_range(0, 255)));
        else
          pending_reqs.push_back(cell_item($urandom_range(0, 255),
                                           $urandom_range(rows - 1, 255)));
      end else begin
        pending_reqs.push_back(cell_item($urandom_range(0, cols - 2),
                                         $urandom_range(0, rows - 2)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset grid, untouched corners first
    pending_reqs.push_back(cell_item(0, 0));
    pending_reqs.push_back(load_item(bpt_pkg::CORNER_00, 32'h8000_0000, 32'h7fff_ffff,
                                     32'h0));
    pending_reqs.push_back(load_item(bpt_pkg::CORNER_10, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff));
    pending_reqs.push_back(load_item(bpt_pkg::CORNER_01, 32'h7fff_ffff, 32'h0,
                                     32'h8000_0000));
    pending_reqs.push_back(load_item(bpt_pkg::CORNER_11, 32'h8000_0000, 32'h7fff_ffff,
                                     32'h7fff_ffff));
    pending_reqs.push_back(cell_item(0, 0));
    pending_reqs.push_back(cell_item(1, 0));
    pending_reqs.push_back(cell_item(0, 1));
    pending_reqs.push_back(cell_item(255, 255));

    set_grid(9'd5, 9'd4);
    pending_reqs.push_back(cell_item(1, 0));
    pending_reqs.push_back(cell_item(0, 0));
    pending_reqs.push_back(cell_item(3, 2));
    pending_reqs.push_back(cell_item(4, 0));
    pending_reqs.push_back(cell_item(0, 3));

    set_grid(9'd256, 9'd256);
    pending_reqs.push_back(cell_item(254, 254));
    pending_reqs.push_back(cell_item(255, 0));
    pending_reqs.push_back(cell_item(0, 255));

    set_grid(9'd0, 9'd7);
    pending_reqs.push_back(cell_item(0, 0));

    // random part
    set_grid(9'd256, 9'd256);
    random_phase(20);
    set_grid(9'd3, 9'd5);
    random_phase(15);
    set_grid(9'd1, 9'd300);
    random_phase(5);
    set_grid(9'd511, 9'd257);
    random_phase(15);
    set_grid(9'd2, 9'd1);
    random_phase(3);
    set_grid(9'($urandom_range(2, 20)), 9'($urandom_range(2, 20)));
    random_phase(17);
    set_grid(9'($urandom_range(2, 40)), 9'($urandom_range(2, 12)));
    random_phase(17);

    drain_all();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
